// ----- src/pfra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfra_pkg: shared types and constants of the page frame allocator
// Frame geometry, command and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pfra_pkg;

	// frame geometry
	localparam int NUM_FRAMES = 16384;
	localparam int FRAME_W    = $clog2(NUM_FRAMES);
	localparam int CNT_W      = 8;
	localparam int CFG_W      = 15;
	localparam int STAT_W     = 3;

	// free bitmap: leaf words in RAM, one summary bit per leaf word in flops
	localparam int WORD_BITS  = 32;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int LEAF_DEPTH = NUM_FRAMES / WORD_BITS;
	localparam int LEAF_AW    = $clog2(LEAF_DEPTH);
	localparam int MID_ROWS   = LEAF_DEPTH / WORD_BITS;
	localparam int ROW_W      = $clog2(MID_ROWS);
	localparam int END_W      = CFG_W + 1;

	// configuration register reset values and indexes
	localparam logic [CFG_W-1:0] FIRST_FREE_RST = 15'd256;
	localparam logic [CFG_W-1:0] FREE_COUNT_RST = 15'd16128;
	localparam logic CFG_FIRST_FREE = 1'b0;
	localparam logic CFG_FREE_COUNT = 1'b1;

	localparam logic [CNT_W-1:0] CNT_ONE = 8'd1;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_SHARE = 2'd2,
		CMD_FAULT = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_FREE    = 3'd1,
		ST_SATURATED  = 3'd2,
		ST_SOLE_OWNER = 3'd3,
		ST_NOT_IN_USE = 3'd4
	} stat_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SWEEP,
		S_READ,
		S_EVAL,
		S_FIND,
		S_TAKE,
		S_WRB,
		S_RESP
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SWEEP,
		OP_EVAL,
		OP_FIND,
		OP_TAKE,
		OP_WRB,
		OP_OUT
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t  op;
		logic range_en;   // sweep frees the configured range
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic sweep_last;
		logic cnt_zero;
		logic cnt_one;
		logic any_free;
		logic out_busy;
	} dp_stat_t;

	// index of the lowest set bit (zero when none is set)
	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (v[b]) idx = BIT_W'(b);
		end
		return idx;
	endfunction

endpackage

// ----- src/pfra_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfra_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pfra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ----- src/pfra_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfra_ctrl: command sequencer
// Steps the datapath through sweeps, count lookups, free frame search and
// result hand-off, one command at a time.
// ----------------------------------------------------------------------------
module pfra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        command,
	output logic              in_stall,
	input  pfra_pkg::dp_stat_t st,
	output pfra_pkg::dp_cmd_t  dcmd
);

	pfra_pkg::state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pfra_pkg::S_CLEAR;
		else         state_q <= state_nxt;
	end

	// next state and datapath commands
	always_comb begin
		state_nxt     = state_q;
		dcmd.op       = pfra_pkg::OP_NONE;
		dcmd.range_en = 1'b0;
		in_stall      = 1'b1;
		case (state_q)
			pfra_pkg::S_CLEAR: begin
				dcmd.op = pfra_pkg::OP_SWEEP;
				if (st.sweep_last) state_nxt = pfra_pkg::S_IDLE;
			end
			pfra_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					dcmd.op = pfra_pkg::OP_LOAD;
					case (pfra_pkg::cmd_t'(command))
						pfra_pkg::CMD_INIT:  state_nxt = pfra_pkg::S_SWEEP;
						pfra_pkg::CMD_ALLOC: state_nxt = pfra_pkg::S_FIND;
						default:             state_nxt = pfra_pkg::S_READ;
					endcase
				end
			end
			pfra_pkg::S_SWEEP: begin
				dcmd.op       = pfra_pkg::OP_SWEEP;
				dcmd.range_en = 1'b1;
				if (st.sweep_last) state_nxt = pfra_pkg::S_RESP;
			end
			pfra_pkg::S_READ: begin
				state_nxt = pfra_pkg::S_EVAL;
			end
			pfra_pkg::S_EVAL: begin
				dcmd.op = pfra_pkg::OP_EVAL;
				if (st.cmd == pfra_pkg::CMD_SHARE || st.cnt_zero || st.cnt_one)
					state_nxt = pfra_pkg::S_RESP;
				else
					state_nxt = pfra_pkg::S_FIND;
			end
			pfra_pkg::S_FIND: begin
				dcmd.op   = pfra_pkg::OP_FIND;
				state_nxt = st.any_free ? pfra_pkg::S_TAKE : pfra_pkg::S_RESP;
			end
			pfra_pkg::S_TAKE: begin
				dcmd.op   = pfra_pkg::OP_TAKE;
				state_nxt = (st.cmd == pfra_pkg::CMD_ALLOC) ? pfra_pkg::S_RESP
				                                            : pfra_pkg::S_WRB;
			end
			pfra_pkg::S_WRB: begin
				dcmd.op   = pfra_pkg::OP_WRB;
				state_nxt = pfra_pkg::S_RESP;
			end
			pfra_pkg::S_RESP: begin
				dcmd.op = pfra_pkg::OP_OUT;
				if (!st.out_busy) state_nxt = pfra_pkg::S_IDLE;
			end
			default: state_nxt = pfra_pkg::S_IDLE;
		endcase
	end

	// count data is only evaluated in the cycle after its read was issued
	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfra_pkg::S_EVAL |-> $past(state_q) == pfra_pkg::S_READ)
		else $error("count evaluated without a preceding read");

	// old count write-back only follows a frame take
	a_wrb_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfra_pkg::S_WRB |-> $past(state_q) == pfra_pkg::S_TAKE)
		else $error("write-back without a frame take");

endmodule

// ----- src/pfra_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfra_dp: reference count and free bitmap datapath
// Count RAM, two-level free bitmap (leaf RAM plus summary flops), the
// configuration registers and the result/output registers.
// ----------------------------------------------------------------------------
module pfra_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pfra_pkg::dp_cmd_t                 dcmd,
	output pfra_pkg::dp_stat_t                st,
	input  logic [1:0]                        command,
	input  logic [pfra_pkg::FRAME_W-1:0]      frame,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [pfra_pkg::CFG_W-1:0]        cfg_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pfra_pkg::STAT_W-1:0]       status,
	output logic [pfra_pkg::FRAME_W-1:0]      frame_out,
	output logic [pfra_pkg::CNT_W-1:0]        count_out
);

	localparam int FW = pfra_pkg::FRAME_W;
	localparam int CW = pfra_pkg::CNT_W;
	localparam int WB = pfra_pkg::WORD_BITS;
	localparam int BW = pfra_pkg::BIT_W;
	localparam int LW = pfra_pkg::LEAF_AW;
	localparam int RW = pfra_pkg::ROW_W;
	localparam int EW = pfra_pkg::END_W;

	// configuration
	logic [pfra_pkg::CFG_W-1:0] first_q, fcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= pfra_pkg::FIRST_FREE_RST;
			fcount_q <= pfra_pkg::FREE_COUNT_RST;
		end else if (cfg_we) begin
			if (cfg_index == pfra_pkg::CFG_FIRST_FREE) first_q  <= cfg_data;
			else                                       fcount_q <= cfg_data;
		end
	end

	// item and working registers
	pfra_pkg::cmd_t     cmd_q;
	logic [FW-1:0]      frame_q, newf_q, sweep_q;
	logic [CW-1:0]      cnt_q;
	logic [LW-1:0]      word_q;
	pfra_pkg::stat_t    res_status_q;
	logic [FW-1:0]      res_frame_q;
	logic [CW-1:0]      res_count_q;

	// output register
	logic               out_valid_q;
	pfra_pkg::stat_t    out_status_q;
	logic [FW-1:0]      out_frame_q;
	logic [CW-1:0]      out_count_q;
	logic               out_busy;

	// summary bits: one per leaf word that holds a free frame
	logic [WB-1:0]      mid_q [pfra_pkg::MID_ROWS];
	logic [pfra_pkg::MID_ROWS-1:0] top;
	logic [BW-1:0]      top_pe, mid_pe, leaf_pe;
	logic [RW-1:0]      top_idx;
	logic [LW-1:0]      find_word;
	logic [FW-1:0]      take_frame;

	// RAM ports
	logic               cnt_we;
	logic [FW-1:0]      cnt_waddr;
	logic [CW-1:0]      cnt_wdata, cnt_rd;
	logic               leaf_we;
	logic [LW-1:0]      leaf_waddr;
	logic [WB-1:0]      leaf_wdata, leaf_rd, leaf_new;

	// sweep range mask for the leaf word under the sweep counter
	logic [EW-1:0]      end_frame;
	logic [WB-1:0]      free_mask;
	logic               sweep_last;

	assign end_frame  = EW'(first_q) + EW'(fcount_q);
	assign sweep_last = &sweep_q;

	always_comb begin
		logic [EW-1:0] fr;
		for (int b = 0; b < WB; b++) begin
			fr = EW'({sweep_q[FW-1:BW], BW'(b)});
			free_mask[b] = dcmd.range_en && (fr >= EW'(first_q)) && (fr < end_frame);
		end
	end

	// first-fit search: summary row, then summary bit, then leaf bit
	always_comb begin
		for (int r = 0; r < pfra_pkg::MID_ROWS; r++) top[r] = |mid_q[r];
	end

	assign top_pe     = pfra_pkg::lowest_set(WB'(top));
	assign top_idx    = top_pe[RW-1:0];
	assign mid_pe     = pfra_pkg::lowest_set(mid_q[top_idx]);
	assign find_word  = {top_idx, mid_pe};
	assign leaf_pe    = pfra_pkg::lowest_set(leaf_rd);
	assign take_frame = {word_q, leaf_pe};
	assign leaf_new   = leaf_rd & ~(WB'(1) << leaf_pe);

	// count RAM write port
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = frame_q;
		cnt_wdata = cnt_rd + CW'(1);
		case (dcmd.op)
			pfra_pkg::OP_SWEEP: begin
				cnt_we    = 1'b1;
				cnt_waddr = sweep_q;
				cnt_wdata = free_mask[sweep_q[BW-1:0]] ? '0 : pfra_pkg::CNT_ONE;
			end
			pfra_pkg::OP_EVAL: begin
				cnt_we = (cmd_q == pfra_pkg::CMD_SHARE) && (cnt_rd != '0)
				         && (cnt_rd != pfra_pkg::CNT_MAX);
			end
			pfra_pkg::OP_TAKE: begin
				cnt_we    = 1'b1;
				cnt_waddr = take_frame;
				cnt_wdata = pfra_pkg::CNT_ONE;
			end
			pfra_pkg::OP_WRB: begin
				cnt_we    = 1'b1;
				cnt_wdata = cnt_q - CW'(1);
			end
			default: cnt_we = 1'b0;
		endcase
	end

	// leaf RAM write port
	always_comb begin
		leaf_we    = 1'b0;
		leaf_waddr = word_q;
		leaf_wdata = leaf_new;
		case (dcmd.op)
			pfra_pkg::OP_SWEEP: begin
				leaf_we    = (sweep_q[BW-1:0] == '0);
				leaf_waddr = sweep_q[FW-1:BW];
				leaf_wdata = free_mask;
			end
			pfra_pkg::OP_TAKE: leaf_we = 1'b1;
			default:           leaf_we = 1'b0;
		endcase
	end

	pfra_ram #(.WIDTH(CW), .DEPTH(pfra_pkg::NUM_FRAMES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (frame_q),
		.rdata (cnt_rd)
	);

	pfra_ram #(.WIDTH(WB), .DEPTH(pfra_pkg::LEAF_DEPTH)) u_leaf_ram (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (leaf_waddr),
		.wdata (leaf_wdata),
		.raddr (find_word),
		.rdata (leaf_rd)
	);

	// summary bits and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < pfra_pkg::MID_ROWS; r++) mid_q[r] <= '0;
			sweep_q <= '0;
		end else begin
			if (dcmd.op == pfra_pkg::OP_SWEEP) begin
				sweep_q <= sweep_q + FW'(1);
				if (sweep_q[BW-1:0] == '0)
					mid_q[sweep_q[FW-1:FW-RW]][sweep_q[FW-RW-1:BW]] <= |free_mask;
			end
			if (dcmd.op == pfra_pkg::OP_TAKE && leaf_new == '0)
				mid_q[word_q[LW-1:BW]][word_q[BW-1:0]] <= 1'b0;
		end
	end

	// item registers and result
	always_ff @(posedge clk) begin
		case (dcmd.op)
			pfra_pkg::OP_LOAD: begin
				cmd_q   <= pfra_pkg::cmd_t'(command);
				frame_q <= frame;
			end
			pfra_pkg::OP_SWEEP: begin
				res_status_q <= pfra_pkg::ST_OK;
				res_frame_q  <= '0;
				res_count_q  <= '0;
			end
			pfra_pkg::OP_EVAL: begin
				cnt_q       <= cnt_rd;
				res_frame_q <= '0;
				if (cnt_rd == '0) begin
					res_status_q <= pfra_pkg::ST_NOT_IN_USE;
					res_count_q  <= '0;
				end else if (cmd_q == pfra_pkg::CMD_SHARE) begin
					if (cnt_rd == pfra_pkg::CNT_MAX) begin
						res_status_q <= pfra_pkg::ST_SATURATED;
						res_count_q  <= pfra_pkg::CNT_MAX;
					end else begin
						res_status_q <= pfra_pkg::ST_OK;
						res_count_q  <= cnt_rd + CW'(1);
					end
				end else if (cnt_rd == pfra_pkg::CNT_ONE) begin
					res_status_q <= pfra_pkg::ST_SOLE_OWNER;
					res_frame_q  <= frame_q;
					res_count_q  <= pfra_pkg::CNT_ONE;
				end
			end
			pfra_pkg::OP_FIND: begin
				word_q       <= find_word;
				// used only when nothing is free
				res_status_q <= pfra_pkg::ST_NO_FREE;
				res_frame_q  <= '0;
				res_count_q  <= (cmd_q == pfra_pkg::CMD_ALLOC) ? '0 : cnt_q;
			end
			pfra_pkg::OP_TAKE: begin
				newf_q       <= take_frame;
				res_status_q <= pfra_pkg::ST_OK;
				res_frame_q  <= take_frame;
				res_count_q  <= pfra_pkg::CNT_ONE;
			end
			pfra_pkg::OP_WRB: begin
				res_status_q <= pfra_pkg::ST_OK;
				res_frame_q  <= newf_q;
				res_count_q  <= cnt_q - CW'(1);
			end
			default: ;
		endcase
	end

	// output register: a result waits here while the next item is taken
	assign out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (dcmd.op == pfra_pkg::OP_OUT && !out_busy) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == pfra_pkg::OP_OUT && !out_busy) begin
			out_status_q <= res_status_q;
			out_frame_q  <= res_frame_q;
			out_count_q  <= res_count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign frame_out = out_frame_q;
	assign count_out = out_count_q;

	// status to controller
	assign st.cmd        = cmd_q;
	assign st.sweep_last = sweep_last;
	assign st.cnt_zero   = (cnt_rd == '0);
	assign st.cnt_one    = (cnt_rd == pfra_pkg::CNT_ONE);
	assign st.any_free   = |top;
	assign st.out_busy   = out_busy;

	// a set summary bit always points at a leaf word with a free frame
	a_leaf_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.op == pfra_pkg::OP_TAKE |-> leaf_rd != '0)
		else $error("summary bit set over an empty leaf word");

	// a fault never hands back the frame it is copying from
	a_fault_new_frame: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.op == pfra_pkg::OP_TAKE && cmd_q == pfra_pkg::CMD_FAULT
		|-> take_frame != frame_q)
		else $error("copy-on-write picked the faulting frame");

	// a result handed to a free output slot shows up on the next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.op == pfra_pkg::OP_OUT && !out_busy |=> out_valid_q)
		else $error("result lost at the output register");

endmodule

// ----- src/page_frame_refcount_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator_unit: page frame allocator with ref counts
// Keeps an 8-bit reference count per frame and a two-level free bitmap;
// serves init, allocate, share and copy-on-write fault commands.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid / in_stall   command[1:0], frame[13:0]
//  output    out_valid / out_stall status[2:0], frame_out[13:0], count_out[7:0]
//  config    cfg_we                cfg_index (0 first_free_frame, 1 free_frame_count),
//                                  cfg_data[14:0]
//
//  One command at a time. Share makes one count RAM read, allocate a summary
//  search and one leaf RAM read, copy-on-write fault one count RAM read, then a
//  summary search and one leaf RAM read. Init sweeps the count RAM one frame a cycle.
//  After reset a clearing pass sets every count to one; input stalls meanwhile,
//  config writes are taken. A result waits in the output register under
//  out_stall while the next command is already taken.
// ----------------------------------------------------------------------------
module page_frame_refcount_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic [pfra_pkg::FRAME_W-1:0]      frame,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pfra_pkg::STAT_W-1:0]       status,
	output logic [pfra_pkg::FRAME_W-1:0]      frame_out,
	output logic [pfra_pkg::CNT_W-1:0]        count_out,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [pfra_pkg::CFG_W-1:0]        cfg_data
);

	pfra_pkg::dp_cmd_t  dcmd;
	pfra_pkg::dp_stat_t dstat;

	pfra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.st       (dstat),
		.dcmd     (dcmd)
	);

	pfra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dcmd      (dcmd),
		.st        (dstat),
		.command   (command),
		.frame     (frame),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.frame_out (frame_out),
		.count_out (count_out)
	);

endmodule
